// ===== rtl/xyr_pkg.sv =====
package xyr_pkg;

	localparam int MAX_RADIX_C   = 16;
	localparam int NUM_DIRS_C    = 4;
	localparam int NODE_W        = 8;
	localparam int RADIX_W       = 5;
	localparam int STATUS_W      = 3;
	localparam int DIR_W         = 2;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd8;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;

	// link status bits
	localparam int BIT_VC0 = 0;
	localparam int BIT_VC1 = 1;
	localparam int BIT_BW  = 2;

	typedef enum logic [1:0] {
		REQ_ROUTE   = 2'd0,
		REQ_CLAIM   = 2'd1,
		REQ_REL_VC  = 2'd2,
		REQ_REL_BW  = 2'd3
	} req_type_t;

	typedef enum logic [DIR_W-1:0] {
		DIR_XP = 2'd0,
		DIR_XN = 2'd1,
		DIR_YP = 2'd2,
		DIR_YN = 2'd3
	} dir_t;

	typedef struct packed {
		logic [NODE_W-1:0]  quot;
		logic [RADIX_W-1:0] rem;
	} div_res_t;

endpackage

// ===== rtl/xyr_div.sv =====
// node id divider: one quotient bit per cycle
module xyr_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [xyr_pkg::NODE_W-1:0] dividend,
	input  logic [xyr_pkg::RADIX_W-1:0] divisor,
	output logic                       done,
	output xyr_pkg::div_res_t          res
);
	import xyr_pkg::*;

	localparam int CNT_W = $clog2(NODE_W);

	logic                run_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [NODE_W-1:0]   quot_q;
	logic [RADIX_W-1:0]  rem_q;
	logic [RADIX_W-1:0]  dsor_q;
	logic [RADIX_W-1:0]  trial;
	logic                ge;

	assign trial = {rem_q[RADIX_W-2:0], quot_q[NODE_W-1]};
	assign ge    = (trial >= dsor_q);
	assign done  = run_q && (cnt_q == CNT_W'(NODE_W-1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (done) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dsor_q <= divisor;
		end else if (run_q) begin
			quot_q <= {quot_q[NODE_W-2:0], ge};
			rem_q  <= ge ? (trial - dsor_q) : trial;
		end
	end

	assign res.quot = quot_q;
	assign res.rem  = rem_q;

endmodule

// ===== rtl/xy_route_vc_link_allocator.sv =====
// Each transaction runs two divisions by the radix in one shared divider,
// then the look-up, the table read and the read-modify-write; a new
// transaction is taken only once the last one has left ST_MOD.
// A finished result may wait in the output register while the next
// transaction is taken. After reset the link table is cleared, one entry per
// cycle, over all MAX_RADIX*MAX_RADIX*4 entries (1024 by default), before in_ready.
module xy_route_vc_link_allocator #(
	parameter int MAX_RADIX = xyr_pkg::MAX_RADIX_C
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [xyr_pkg::RADIX_W-1:0] cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  req_type,
	input  logic [xyr_pkg::NODE_W-1:0]  from_node,
	input  logic [xyr_pkg::NODE_W-1:0]  to_node,
	input  logic                        vc_id,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [xyr_pkg::NODE_W-1:0]  next_node,
	output logic                        vc_granted,
	output logic                        route_ok,
	output logic                        bw_granted,
	output logic                        req_error
);
	import xyr_pkg::*;

	localparam int DEPTH = MAX_RADIX * MAX_RADIX * NUM_DIRS_C;
	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(MAX_RADIX);

	typedef enum logic [6:0] {
		ST_CLR   = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_DIVA  = 7'b0000100,
		ST_DIVB0 = 7'b0001000,
		ST_DIVB  = 7'b0010000,
		ST_READ  = 7'b0100000,
		ST_MOD   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	logic [RADIX_W-1:0]  mesh_radix_q;
	logic [RADIX_W-1:0]  radix_eff;
	logic [RADIX_W-1:0]  r_q;
	logic [IDX_W-1:0]    clr_q;
	req_type_t           type_q;
	logic [NODE_W-1:0]   from_q;
	logic [NODE_W-1:0]   to_q;
	logic                vc_q;
	logic [RADIX_W-1:0]  ax_q;
	logic [NODE_W-1:0]   ay_q;

	logic                div_start;
	logic [NODE_W-1:0]   div_dividend;
	logic                div_done;
	div_res_t            div_res;

	logic [RADIX_W-1:0]  bx;
	logic [NODE_W-1:0]   by;
	logic                err_c, skip_c;
	dir_t                dir_c;
	logic [NODE_W-1:0]   nb_c;
	logic                err_q, skip_q;
	dir_t                dir_q;
	logic [NODE_W-1:0]   nb_q;
	logic                look_q;

	logic [STATUS_W-1:0] link_mem [DEPTH];
	logic [STATUS_W-1:0] rd_q;
	logic [IDX_W-1:0]    idx;
	logic                mem_we;
	logic [IDX_W-1:0]    mem_wa;
	logic [STATUS_W-1:0] mem_wd;

	logic                out_free;
	logic                mod_fire;
	logic [STATUS_W-1:0] st_new;
	logic                wr_c, ok_c, vcg_c, bw_c;

	assign radix_eff = (mesh_radix_q < RADIX_MIN) ? RADIX_MIN :
	                   (mesh_radix_q > RADIX_MAX) ? RADIX_MAX : mesh_radix_q;

	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid || out_ready;
	assign mod_fire = (state_q == ST_MOD) && out_free;

	assign div_start    = (in_valid && in_ready) || (state_q == ST_DIVB0);
	assign div_dividend = (state_q == ST_DIVB0) ? to_q : from_node;

	xyr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  ((state_q == ST_DIVB0) ? r_q : radix_eff),
		.done     (div_done),
		.res      (div_res)
	);

	// look-up on both coordinates, evaluated once the second division's results have settled
	assign bx = div_res.rem;
	assign by = div_res.quot;

	always_comb begin
		err_c  = (ay_q >= NODE_W'(r_q)) || (by >= NODE_W'(r_q));
		skip_c = 1'b0;
		dir_c  = DIR_XP;
		nb_c   = '0;
		if (type_q == REQ_ROUTE) begin
			skip_c = (from_q == to_q);
			if (bx != ax_q) begin
				dir_c = (bx > ax_q) ? DIR_XP : DIR_XN;
				nb_c  = (bx > ax_q) ? (from_q + 1'b1) : (from_q - 1'b1);
			end else begin
				dir_c = (by > ay_q) ? DIR_YP : DIR_YN;
				nb_c  = (by > ay_q) ? (from_q + NODE_W'(r_q)) : (from_q - NODE_W'(r_q));
			end
		end else begin
			if (ay_q == by && {1'b0, bx} == {1'b0, ax_q} + 1'b1) begin
				dir_c = DIR_XP;
			end else if (ay_q == by && {1'b0, ax_q} == {1'b0, bx} + 1'b1) begin
				dir_c = DIR_XN;
			end else if (ax_q == bx && {1'b0, by} == {1'b0, ay_q} + 1'b1) begin
				dir_c = DIR_YP;
			end else if (ax_q == bx && {1'b0, ay_q} == {1'b0, by} + 1'b1) begin
				dir_c = DIR_YN;
			end else begin
				err_c = 1'b1;
			end
		end
	end

	assign idx = IDX_W'(from_q * NUM_DIRS_C + int'(dir_q));

	// read-modify-write of one link entry
	always_comb begin
		st_new = rd_q;
		wr_c   = 1'b0;
		ok_c   = 1'b0;
		vcg_c  = 1'b0;
		bw_c   = 1'b0;
		if (!skip_q) begin
			case (type_q)
				REQ_ROUTE: begin
					if (!rd_q[BIT_VC0]) begin
						ok_c = 1'b1;
						st_new[BIT_VC0] = 1'b1;
					end else if (!rd_q[BIT_VC1]) begin
						ok_c  = 1'b1;
						vcg_c = 1'b1;
						st_new[BIT_VC1] = 1'b1;
					end
					if (ok_c) begin
						bw_c = !rd_q[BIT_BW];
						st_new[BIT_BW] = 1'b1;
					end
					wr_c = ok_c;
				end
				REQ_CLAIM: begin
					bw_c = !rd_q[BIT_BW];
					st_new[BIT_BW] = 1'b1;
					wr_c = 1'b1;
				end
				REQ_REL_VC: begin
					if (vc_q) begin
						st_new[BIT_VC1] = 1'b0;
					end else begin
						st_new[BIT_VC0] = 1'b0;
					end
					wr_c = 1'b1;
				end
				REQ_REL_BW: begin
					st_new[BIT_BW] = 1'b0;
					wr_c = 1'b1;
				end
				default: begin
					wr_c = 1'b0;
				end
			endcase
		end
	end

	assign mem_we = (state_q == ST_CLR) || (mod_fire && wr_c);
	assign mem_wa = (state_q == ST_CLR) ? clr_q : idx;
	assign mem_wd = (state_q == ST_CLR) ? '0 : st_new;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_wa] <= mem_wd;
		end
		if (state_q == ST_READ) begin
			rd_q <= link_mem[idx];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLR: begin
				if (clr_q == IDX_W'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DIVA;
				end
			end
			ST_DIVA: begin
				if (div_done) begin
					state_d = ST_DIVB0;
				end
			end
			ST_DIVB0: state_d = ST_DIVB;
			ST_DIVB: begin
				if (div_done) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				// the look-up is registered first, then the entry is read
				if (look_q) begin
					state_d = ST_READ;
				end else begin
					state_d = ST_MOD;
				end
			end
			ST_MOD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			clr_q        <= '0;
			mesh_radix_q <= RADIX_RESET;
			out_valid    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_we) begin
				mesh_radix_q <= cfg_wdata;
			end
			if (mod_fire) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// divider results settle only in the cycle after done, so the look-up
	// is registered when look_q flags that cycle for ST_DIVB
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			look_q <= 1'b0;
		end else begin
			look_q <= (state_q == ST_DIVB) && div_done;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			type_q <= req_type_t'(req_type);
			from_q <= from_node;
			to_q   <= to_node;
			vc_q   <= vc_id;
			r_q    <= radix_eff;
		end
		if (state_q == ST_DIVB0) begin
			ax_q <= div_res.rem;
			ay_q <= div_res.quot;
		end
		if (look_q) begin
			err_q  <= err_c;
			skip_q <= skip_c || err_c;
			dir_q  <= dir_c;
			nb_q   <= nb_c;
		end
		if (mod_fire) begin
			next_node  <= ok_c ? nb_q : '0;
			vc_granted <= vcg_c;
			route_ok   <= ok_c;
			bw_granted <= bw_c;
			req_error  <= err_q;
		end
	end

endmodule

// ===== rtl/xyr_checker.sv =====
module xyr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [xyr_pkg::NODE_W-1:0]  next_node,
	input logic                        vc_granted,
	input logic                        route_ok,
	input logic                        bw_granted,
	input logic                        req_error
);
	import xyr_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(next_node) && $stable(route_ok)
			&& $stable(bw_granted) && $stable(req_error) && $stable(vc_granted))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("transaction accepted while busy");

	a_no_route_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !route_ok |-> next_node == '0 && !vc_granted)
		else $error("route fields set without a route");

	a_err_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && req_error |-> !route_ok && !bw_granted)
		else $error("grant reported with an error");

endmodule

bind xy_route_vc_link_allocator xyr_checker u_xyr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.next_node  (next_node),
	.vc_granted (vc_granted),
	.route_ok   (route_ok),
	.bw_granted (bw_granted),
	.req_error  (req_error)
);
